[design/stcr_pkg.sv]
package stcr_pkg;

  // Trace geometry
  localparam int TRACE_COLUMNS = 280;

  // Field widths
  localparam int CODE_W  = 8;
  localparam int COL_W   = 11;
  localparam int ROW_W   = 12;
  localparam int GAIN_W  = 24;
  localparam int POS_W   = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Row arithmetic widths: (code diff) x gain, then bottom row offset added
  localparam int PROD_W = CODE_W + 1 + GAIN_W + 1;
  localparam int NUM_W  = PROD_W + 1;
  localparam int FRAC_W = 16;
  localparam int RAW_W  = NUM_W - FRAC_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_FLOOR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_COLUMN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_ROW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_GAIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_POINTS_ONLY = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_MODE   = 3'd6;

  // Draw command codes
  localparam logic [1:0] DRAW_POINT  = 2'd0;
  localparam logic [1:0] DRAW_SPAN   = 2'd1;
  localparam logic [1:0] DRAW_POINTS = 2'd2;

  typedef struct packed {
    logic [CODE_W-1:0] sample_first;
    logic [CODE_W-1:0] sample_second;
    logic              frame_start;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0]        column_x;
    logic signed [ROW_W-1:0] row_a;
    logic signed [ROW_W-1:0] row_b;
    logic [1:0]              draw_op;
  } out_item_t;

  // Draw mode that travels with an item down the pipeline
  typedef struct packed {
    logic peak;
    logic points_only;
  } draw_ctrl_t;

endpackage

[design/stcr_draw_decide.sv]
module stcr_draw_decide (
  input  stcr_pkg::draw_ctrl_t                   ctrl,
  input  logic [stcr_pkg::COL_W-1:0]             column_x,
  input  logic signed [stcr_pkg::RAW_W-1:0]      row0,
  input  logic signed [stcr_pkg::RAW_W-1:0]      row1,
  input  logic signed [stcr_pkg::RAW_W-1:0]      row2,
  input  logic signed [stcr_pkg::RAW_W-1:0]      row3,
  output stcr_pkg::out_item_t                    item
);

  localparam int EXT_W = stcr_pkg::RAW_W + 1;

  function automatic logic signed [stcr_pkg::ROW_W-1:0] sat_row(
    input logic signed [EXT_W-1:0] r
  );
    logic signed [EXT_W-1:0] lo;
    logic signed [EXT_W-1:0] hi;
    lo = -(EXT_W'(1) <<< (stcr_pkg::ROW_W - 1));
    hi = (EXT_W'(1) <<< (stcr_pkg::ROW_W - 1)) - EXT_W'(1);
    if (r < lo) begin
      sat_row = lo[stcr_pkg::ROW_W-1:0];
    end else if (r > hi) begin
      sat_row = hi[stcr_pkg::ROW_W-1:0];
    end else begin
      sat_row = r[stcr_pkg::ROW_W-1:0];
    end
  endfunction

  logic signed [EXT_W-1:0] r0;
  logic signed [EXT_W-1:0] r1;
  logic signed [EXT_W-1:0] r2;
  logic signed [EXT_W-1:0] r3;
  logic signed [EXT_W-1:0] up;
  logic signed [EXT_W-1:0] dn;
  logic signed [EXT_W-1:0] a;
  logic signed [EXT_W-1:0] b;
  logic [1:0]              op;

  assign r0 = EXT_W'(row0);
  assign r1 = EXT_W'(row1);
  assign r2 = EXT_W'(row2);
  assign r3 = EXT_W'(row3);

  // Widen the held peak span toward the next column's span
  always_comb begin
    up = (r3 < r0) ? r3 + EXT_W'(1) : r0;
    dn = (r2 > r1) ? r2 - EXT_W'(1) : r1;
  end

  // Pick the command: row0 is the held row, row1 the join target in normal mode
  always_comb begin
    a  = r0;
    b  = '0;
    op = stcr_pkg::DRAW_POINT;
    if (ctrl.peak) begin
      a = up;
      if (ctrl.points_only) begin
        b  = dn;
        op = stcr_pkg::DRAW_POINTS;
      end else if (up != dn) begin
        b  = dn;
        op = stcr_pkg::DRAW_SPAN;
      end
    end else if (!ctrl.points_only) begin
      if (r1 < r0) begin
        b  = r1 + EXT_W'(1);
        op = stcr_pkg::DRAW_SPAN;
      end else if (r1 > r0) begin
        b  = r1 - EXT_W'(1);
        op = stcr_pkg::DRAW_SPAN;
      end
    end
  end

  assign item.column_x = column_x;
  assign item.row_a    = sat_row(a);
  assign item.row_b    = sat_row(b);
  assign item.draw_op  = op;

endmodule

[design/scope_trace_column_rasterizer_top.sv]
// Channel | Signals                          | Moves
// --------+----------------------------------+-----------------------------------
// input   | in_valid, in_ready, in_item      | one screen column (sample or pair)
// output  | out_valid, out_ready, out_item   | one draw command for a held column
// config  | cfg_we, cfg_index, cfg_wdata     | one register write, no wait
//
// One item is accepted per cycle while in_ready is high. A draw command shows on
// out_valid once the item completing its column has been accepted, through four
// register stages: code select, multiply by row_gain, row scaling, then draw
// decision into the output register.
// Reset is synchronous; config returns to defaults and no column is held.
// A stalled output backs up stage by stage; in_ready drops only while all
// four stages hold commands and out_ready is low. Items that draw nothing
// leave no bubble.
module scope_trace_column_rasterizer_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  stcr_pkg::in_item_t                   in_item,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output stcr_pkg::out_item_t                  out_item,
  input  logic                                 cfg_we,
  input  logic [stcr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [stcr_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int CW = stcr_pkg::CODE_W;

  function automatic logic [CW-1:0] clamp_code(
    input logic [CW-1:0] v,
    input logic [CW-1:0] lo,
    input logic [CW-1:0] hi
  );
    if (v < lo) begin
      clamp_code = lo;
    end else if (v > hi) begin
      clamp_code = hi;
    end else begin
      clamp_code = v;
    end
  endfunction

  // Configuration registers
  logic [CW-1:0]                   code_floor_r;
  logic [CW-1:0]                   max_value_r;
  logic [stcr_pkg::POS_W-1:0]      left_column_r;
  logic [stcr_pkg::POS_W-1:0]      bottom_row_r;
  logic [stcr_pkg::GAIN_W-1:0]     row_gain_r;
  logic                            points_only_r;
  logic                            peak_mode_r;

  // Held column
  logic [CW-1:0]                   held_first_r;
  logic [CW-1:0]                   held_second_r;
  logic                            held_valid_r;
  logic [stcr_pkg::COL_W-1:0]      col_idx_r;
  logic [stcr_pkg::COL_W-1:0]      col_idx_nxt;

  // Pipeline
  logic                            s1_valid_r;
  logic                            s2_valid_r;
  logic                            s3_valid_r;
  logic                            out_valid_r;
  logic                            rdy1;
  logic                            rdy2;
  logic                            rdy3;
  logic                            rdy4;
  logic                            accept;
  logic                            draw_en;

  logic [CW-1:0]                   code_nxt [4];
  logic [CW-1:0]                   s1_code_r [4];
  logic [stcr_pkg::COL_W-1:0]      col_x_nxt;
  logic [stcr_pkg::COL_W-1:0]      s1_col_r;
  logic [stcr_pkg::COL_W-1:0]      s2_col_r;
  logic [stcr_pkg::COL_W-1:0]      s3_col_r;
  stcr_pkg::draw_ctrl_t            ctrl_nxt;
  stcr_pkg::draw_ctrl_t            s1_ctrl_r;
  stcr_pkg::draw_ctrl_t            s2_ctrl_r;
  stcr_pkg::draw_ctrl_t            s3_ctrl_r;

  logic signed [stcr_pkg::PROD_W-1:0] prod_nxt [4];
  logic signed [stcr_pkg::PROD_W-1:0] s2_prod_r [4];
  logic signed [stcr_pkg::RAW_W-1:0]  row_nxt [4];
  logic signed [stcr_pkg::RAW_W-1:0]  s3_row_r [4];
  stcr_pkg::out_item_t                item_nxt;
  stcr_pkg::out_item_t                out_item_r;

  logic [CW-1:0] h_lo;
  logic [CW-1:0] h_hi;
  logic [CW-1:0] n_lo;
  logic [CW-1:0] n_hi;
  logic [CW-1:0] hc1;
  logic [CW-1:0] hc2;
  logic [CW-1:0] nc1;
  logic [CW-1:0] nc2;
  logic          held_has;
  logic          new_has;

  // Stage readiness: a stage takes new data when empty or draining
  assign rdy4     = !out_valid_r || out_ready;
  assign rdy3     = !s3_valid_r || rdy4;
  assign rdy2     = !s2_valid_r || rdy3;
  assign rdy1     = !s1_valid_r || rdy2;
  assign in_ready = rdy1;
  assign accept   = in_valid && in_ready;

  // Write configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_floor_r  <= CW'(2);
      max_value_r   <= CW'(252);
      left_column_r <= '0;
      bottom_row_r  <= '0;
      row_gain_r    <= stcr_pkg::GAIN_W'(65536);
      points_only_r <= 1'b0;
      peak_mode_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        stcr_pkg::CFG_CODE_FLOOR:  code_floor_r  <= cfg_wdata[CW-1:0];
        stcr_pkg::CFG_MAX_VALUE:   max_value_r   <= cfg_wdata[CW-1:0];
        stcr_pkg::CFG_LEFT_COLUMN: left_column_r <= cfg_wdata[stcr_pkg::POS_W-1:0];
        stcr_pkg::CFG_BOTTOM_ROW:  bottom_row_r  <= cfg_wdata[stcr_pkg::POS_W-1:0];
        stcr_pkg::CFG_ROW_GAIN:    row_gain_r    <= cfg_wdata[stcr_pkg::GAIN_W-1:0];
        stcr_pkg::CFG_POINTS_ONLY: points_only_r <= cfg_wdata[0];
        stcr_pkg::CFG_PEAK_MODE:   peak_mode_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Clamp and sort held and new pairs; decide whether the held column draws
  always_comb begin
    hc1  = clamp_code(held_first_r, code_floor_r, max_value_r);
    hc2  = clamp_code(held_second_r, code_floor_r, max_value_r);
    nc1  = clamp_code(in_item.sample_first, code_floor_r, max_value_r);
    nc2  = clamp_code(in_item.sample_second, code_floor_r, max_value_r);
    h_lo = (hc1 < hc2) ? hc1 : hc2;
    h_hi = (hc1 < hc2) ? hc2 : hc1;
    new_has  = (in_item.sample_first != '0) && (in_item.sample_second != '0);
    n_lo = new_has ? ((nc1 < nc2) ? nc1 : nc2) : h_lo;
    n_hi = new_has ? ((nc1 < nc2) ? nc2 : nc1) : h_hi;
    held_has = peak_mode_r ? (held_first_r != '0) && (held_second_r != '0)
                           : (held_first_r != '0);
    draw_en  = held_valid_r && !in_item.frame_start && held_has &&
               (col_idx_r < stcr_pkg::COL_W'(stcr_pkg::TRACE_COLUMNS));
    if (peak_mode_r) begin
      code_nxt[0] = h_hi;
      code_nxt[1] = h_lo;
      code_nxt[2] = n_hi;
      code_nxt[3] = n_lo;
    end else begin
      code_nxt[0] = hc1;
      code_nxt[1] = in_item.sample_first;
      code_nxt[2] = hc1;
      code_nxt[3] = hc1;
    end
    ctrl_nxt.peak        = peak_mode_r;
    ctrl_nxt.points_only = points_only_r;
    col_x_nxt = stcr_pkg::COL_W'(left_column_r) + col_idx_r;
    if (in_item.frame_start || !held_valid_r) begin
      col_idx_nxt = '0;
    end else if (col_idx_r != '1) begin
      col_idx_nxt = col_idx_r + stcr_pkg::COL_W'(1);
    end else begin
      col_idx_nxt = col_idx_r;
    end
  end

  // Hold the new column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_first_r  <= '0;
      held_second_r <= '0;
      held_valid_r  <= 1'b0;
      col_idx_r     <= '0;
    end else if (accept) begin
      held_first_r  <= in_item.sample_first;
      held_second_r <= in_item.sample_second;
      held_valid_r  <= 1'b1;
      col_idx_r     <= col_idx_nxt;
    end
  end

  // Scale: (floor - code) * row_gain, one 9 x 25 bit signed multiply per code lane
  always_comb begin
    logic signed [CW:0]                  diff;
    logic signed [stcr_pkg::GAIN_W:0]    gain_s;
    gain_s = $signed({1'b0, row_gain_r});
    for (int i = 0; i < 4; i++) begin
      diff        = $signed({1'b0, code_floor_r}) - $signed({1'b0, s1_code_r[i]});
      prod_nxt[i] = stcr_pkg::PROD_W'(diff) * stcr_pkg::PROD_W'(gain_s);
    end
  end

  // Add the bottom row and drop the fraction, rounding toward zero
  always_comb begin
    logic signed [stcr_pkg::NUM_W-1:0] num;
    for (int i = 0; i < 4; i++) begin
      num = stcr_pkg::NUM_W'($signed({1'b0, bottom_row_r, {stcr_pkg::FRAC_W{1'b0}}})) +
            stcr_pkg::NUM_W'(s2_prod_r[i]);
      row_nxt[i] = num[stcr_pkg::NUM_W-1:stcr_pkg::FRAC_W];
      if (num[stcr_pkg::NUM_W-1] && (num[stcr_pkg::FRAC_W-1:0] != '0)) begin
        row_nxt[i] = row_nxt[i] + stcr_pkg::RAW_W'(1);
      end
    end
  end

  stcr_draw_decide u_decide (
    .ctrl     (s3_ctrl_r),
    .column_x (s3_col_r),
    .row0     (s3_row_r[0]),
    .row1     (s3_row_r[1]),
    .row2     (s3_row_r[2]),
    .row3     (s3_row_r[3]),
    .item     (item_nxt)
  );

  // Advance pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) begin
        s1_valid_r <= accept && draw_en;
      end
      if (rdy2) begin
        s2_valid_r <= s1_valid_r;
      end
      if (rdy3) begin
        s3_valid_r <= s2_valid_r;
      end
      if (rdy4) begin
        out_valid_r <= s3_valid_r;
      end
    end
  end

  // Advance pipeline payload
  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_code_r <= code_nxt;
      s1_col_r  <= col_x_nxt;
      s1_ctrl_r <= ctrl_nxt;
    end
    if (rdy2) begin
      s2_prod_r <= prod_nxt;
      s2_col_r  <= s1_col_r;
      s2_ctrl_r <= s1_ctrl_r;
    end
    if (rdy3) begin
      s3_row_r  <= row_nxt;
      s3_col_r  <= s2_col_r;
      s3_ctrl_r <= s2_ctrl_r;
    end
    if (rdy4) begin
      out_item_r <= item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[design/stcr_checker.sv]
module stcr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input stcr_pkg::out_item_t out_item
);

  // Stalled command holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled draw command changed");

  // Only defined draw codes leave the block
  a_op_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.draw_op == stcr_pkg::DRAW_POINT) ||
                  (out_item.draw_op == stcr_pkg::DRAW_SPAN) ||
                  (out_item.draw_op == stcr_pkg::DRAW_POINTS))
    else $error("undefined draw code");

  // A single point carries a zero second row
  a_point_row_b: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.draw_op == stcr_pkg::DRAW_POINT) |-> out_item.row_b == '0)
    else $error("point command with nonzero second row");

  // Reset flushes pending commands
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("draw command present after reset");

endmodule

bind scope_trace_column_rasterizer_top stcr_checker u_stcr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

[verif/tb_scope_trace_column_rasterizer_top.sv]
module tb_scope_trace_column_rasterizer_top;
  import stcr_pkg::*;

  // Column predictor: mirrors the register copy and the held column, queues draw commands
  class draw_scoreboard;
    longint min_v, max_v, left_col, bottom, gain;
    bit points_only, peak;
    longint held_first, held_second, col_idx;
    bit held_valid;
    out_item_t expected_draws[$];
    int fail_count;

    function new();
      min_v = 2;
      max_v = 252;
      left_col = 0;
      bottom = 0;
      gain = 65536;
      points_only = 0;
      peak = 0;
      held_first = 0;
      held_second = 0;
      col_idx = 0;
      held_valid = 0;
      fail_count = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_CODE_FLOOR:  min_v = val[7:0];
        CFG_MAX_VALUE:   max_v = val[7:0];
        CFG_LEFT_COLUMN: left_col = val[9:0];
        CFG_BOTTOM_ROW:  bottom = val[9:0];
        CFG_ROW_GAIN:    gain = val[23:0];
        CFG_POINTS_ONLY: points_only = val[0];
        CFG_PEAK_MODE:   peak = val[0];
        default: ;
      endcase
    endfunction

    // Map a code to a screen row; larger codes sit higher (smaller row)
    function longint row_of(longint code);
      longint num;
      num = bottom * 65536 + (min_v - code) * gain;
      return num / 65536;
    endfunction

    function longint clamp(longint code);
      if (code < min_v) return min_v;
      if (code > max_v) return max_v;
      return code;
    endfunction

    function logic [ROW_W-1:0] sat_row(longint r);
      if (r < -2048) r = -2048;
      else if (r > 2047) r = 2047;
      return r[ROW_W-1:0];
    endfunction

    function void sort_pair(longint p, longint q, output longint lo, output longint hi);
      p = clamp(p);
      q = clamp(q);
      if (p < q) begin
        lo = p;
        hi = q;
      end else begin
        lo = q;
        hi = p;
      end
    endfunction

    function void push_draw(longint a, longint b, logic [1:0] op);
      out_item_t e;
      e.column_x = COL_W'(left_col + col_idx);
      e.row_a = sat_row(a);
      e.row_b = sat_row(b);
      e.draw_op = op;
      expected_draws.push_back(e);
    endfunction

    // Draw the held column toward the new one, then hold the new column
    function void note_column(in_item_t it);
      longint s1, s2, y, yn, lo, hi, nlo, nhi, up, dn, nup, ndn;
      s1 = it.sample_first;
      s2 = it.sample_second;
      if (held_valid && !it.frame_start && col_idx < TRACE_COLUMNS) begin
        if (peak) begin
          if (held_first != 0 && held_second != 0) begin
            sort_pair(held_first, held_second, lo, hi);
            if (s1 == 0 || s2 == 0) begin
              nlo = lo;
              nhi = hi;
            end else begin
              sort_pair(s1, s2, nlo, nhi);
            end
            up = row_of(hi);
            dn = row_of(lo);
            nup = row_of(nhi);
            ndn = row_of(nlo);
            if (ndn < up) up = ndn + 1;
            if (nup > dn) dn = nup - 1;
            if (points_only) push_draw(up, dn, DRAW_POINTS);
            else if (up == dn) push_draw(up, 0, DRAW_POINT);
            else push_draw(up, dn, DRAW_SPAN);
          end
        end else if (held_first != 0) begin
          y = row_of(clamp(held_first));
          yn = row_of(s1);
          if (points_only) push_draw(y, 0, DRAW_POINT);
          else if (yn < y) push_draw(y, yn + 1, DRAW_SPAN);
          else if (yn > y) push_draw(y, yn - 1, DRAW_SPAN);
          else push_draw(y, 0, DRAW_POINT);
        end
      end
      if (it.frame_start || !held_valid) col_idx = 0;
      else if (col_idx < 2047) col_idx = col_idx + 1;
      held_first = s1;
      held_second = s2;
      held_valid = 1;
    endfunction

    function void flag(string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
    endfunction

    function void check_command(out_item_t got);
      out_item_t exp;
      if (expected_draws.size() == 0) begin
        flag($sformatf("unexpected draw: x=%0d a=%0d b=%0d op=%0d",
                       got.column_x, got.row_a, got.row_b, got.draw_op));
        return;
      end
      exp = expected_draws.pop_front();
      if (got.column_x !== exp.column_x || got.row_a !== exp.row_a ||
          got.row_b !== exp.row_b || got.draw_op !== exp.draw_op)
        flag($sformatf("draw mismatch: exp x=%0d a=%0d b=%0d op=%0d, got x=%0d a=%0d b=%0d op=%0d",
                       exp.column_x, exp.row_a, exp.row_b, exp.draw_op,
                       got.column_x, got.row_a, got.row_b, got.draw_op));
    endfunction

    function int waiting();
      return expected_draws.size();
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  draw_scoreboard sb = new();
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit hold_long = 1'b0;

  scope_trace_column_rasterizer_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

  // Check every accepted draw command
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_command(out_item);
  end

  // Drive out_ready: random stall bursts, plus one long hold-off on request
  initial begin
    int k;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_long) begin
        out_ready <= 1'b0;
        repeat (80) @(posedge clk);
        hold_long = 1'b0;
        out_ready <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        k = $urandom_range(1, 7);
        out_ready <= 1'b0;
        repeat (k) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  function automatic in_item_t col_item(logic [7:0] s1, logic [7:0] s2, logic fs);
    in_item_t it;
    it.sample_first = s1;
    it.sample_second = s2;
    it.frame_start = fs;
    return it;
  endfunction

  // Bias codes toward absent, the clamp limits and the code extremes
  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 11))
      0: return 8'd0;
      1: return 8'(sb.min_v);
      2: return 8'(sb.max_v);
      3: return 8'd255;
      4: return 8'd1;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one item, hold it until accepted, then maybe pause the sender
  task automatic send_column(input in_item_t it);
    int gap;
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_column(it);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  // Wait for all draws, then let the pipeline empty of items that draw nothing
  task automatic settle();
    while (sb.waiting() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [7:0] mn, input logic [7:0] mx,
                               input logic [9:0] left, input logic [9:0] bot,
                               input logic [23:0] g, input bit po, input bit pk);
    write_reg(CFG_CODE_FLOOR, CFG_DATA_W'(mn));
    write_reg(CFG_MAX_VALUE, CFG_DATA_W'(mx));
    write_reg(CFG_LEFT_COLUMN, CFG_DATA_W'(left));
    write_reg(CFG_BOTTOM_ROW, CFG_DATA_W'(bot));
    write_reg(CFG_ROW_GAIN, g);
    write_reg(CFG_POINTS_ONLY, CFG_DATA_W'(po));
    write_reg(CFG_PEAK_MODE, CFG_DATA_W'(pk));
    cfg_we <= 1'b0;
  endtask

  // Random columns in frames; a nonzero first_frame opens with one long frame
  task automatic run_random(input int n_items, input int first_frame);
    int cols_left;
    in_item_t it;
    cols_left = first_frame;
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0 && rx_idle_on) tx_idle_on = ($urandom_range(0, 3) != 0);
      it.sample_first = pick_code();
      it.sample_second = pick_code();
      it.frame_start = (i == 0 && first_frame > 0) || cols_left == 0 ||
                       (i >= first_frame && cols_left < 100 && $urandom_range(0, 49) == 0);
      if (it.frame_start && !(i == 0 && first_frame > 0)) cols_left = $urandom_range(3, 60);
      else if (cols_left > 0) cols_left--;
      send_column(it);
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Normal mode under reset settings: first item without frame start, absent codes,
    // clamp limits, equal rows, joins up and down, frame start dropping the held column
    send_column(col_item(8'd100, 8'd0, 1'b0));
    send_column(col_item(8'd120, 8'd0, 1'b0));
    send_column(col_item(8'd120, 8'd9, 1'b0));
    send_column(col_item(8'd0, 8'd0, 1'b0));
    send_column(col_item(8'd255, 8'd0, 1'b0));
    send_column(col_item(8'd1, 8'd255, 1'b0));
    send_column(col_item(8'd2, 8'd0, 1'b0));
    send_column(col_item(8'd252, 8'd0, 1'b0));
    send_column(col_item(8'd255, 8'd255, 1'b1));
    send_column(col_item(8'd1, 8'd0, 1'b0));
    send_column(col_item(8'd0, 8'd0, 1'b0));
    send_column(col_item(8'd200, 8'd77, 1'b0));
    in_valid <= 1'b0;
    settle();

    // Peak mode: swapped pairs, absent new pair, held pair with a zero, widening
    write_reg(CFG_PEAK_MODE, CFG_DATA_W'(1));
    cfg_we <= 1'b0;
    send_column(col_item(8'd10, 8'd200, 1'b1));
    send_column(col_item(8'd200, 8'd10, 1'b0));
    send_column(col_item(8'd0, 8'd50, 1'b0));
    send_column(col_item(8'd60, 8'd0, 1'b0));
    send_column(col_item(8'd255, 8'd1, 1'b0));
    send_column(col_item(8'd100, 8'd100, 1'b0));
    send_column(col_item(8'd1, 8'd255, 1'b0));
    send_column(col_item(8'd30, 8'd40, 1'b1));
    send_column(col_item(8'd35, 8'd38, 1'b0));
    send_column(col_item(8'd250, 8'd5, 1'b0));
    in_valid <= 1'b0;
    settle();

    // Peak mode, dots only
    write_reg(CFG_POINTS_ONLY, CFG_DATA_W'(1));
    cfg_we <= 1'b0;
    send_column(col_item(8'd40, 8'd90, 1'b0));
    send_column(col_item(8'd120, 8'd200, 1'b0));
    send_column(col_item(8'd70, 8'd70, 1'b0));
    in_valid <= 1'b0;
    settle();

    // Random phases over extreme and random settings
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: apply_setting(8'd0, 8'd255, 10'd1023, 10'd1023, 24'hFFFFFF, 1'b0, 1'b0);
        1: apply_setting(8'd255, 8'd0, 10'd0, 10'd0, 24'd0, 1'b1, 1'b1);
        6: apply_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                         24'($urandom_range(0, 24'hFFFFFF)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
        default: apply_setting(8'($urandom_range(0, 60)), 8'($urandom_range(180, 255)),
                               10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                               24'($urandom_range(0, 24'h3FFFF)),
                               (p == 3 || p == 5) ? 1'b1 :
                               (p == 7 ? 1'($urandom_range(0, 1)) : 1'b0),
                               (p == 4 || p == 5) ? 1'b1 :
                               (p == 7 ? 1'($urandom_range(0, 1)) : 1'b0));
      endcase
      if (p == 2) begin
        // Long receiver hold-off while columns keep coming; run past the trace end
        hold_long = 1'b1;
        run_random(320, 300);
      end else if (p == 7) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_random(80, 0);
      end else begin
        run_random(80, 0);
      end
      settle();
    end

    repeat (20) @(posedge clk);
    if (sb.fail_count == 0 && sb.waiting() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
